// ----- design/wmss_pkg.sv -----
// ----------------------------------------------------------------------------
// wmss_pkg - shared types and constants
// field widths, register indexes and the sequencer state type
// ----------------------------------------------------------------------------
package wmss_pkg;

  localparam int CHANNEL_W = 8;
  localparam int MINUTE_W  = 11;
  localparam int MINS_W    = 4;
  localparam int DATA_W    = 24;   // channel + minute rounded up to bytes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT = 1'd1;

  localparam logic [MINS_W-1:0]   MIN_SAMPLES_RST  = 4'd4;
  localparam logic [MINUTE_W-1:0] SPREAD_LIMIT_RST = 11'd60;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_META = 6'b000010,
    S_LOAD = 6'b000100,
    S_RANK = 6'b001000,
    S_EVAL = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

endpackage

// ----- design/window_median_spread_suggester.sv -----
// ----------------------------------------------------------------------------
// window_median_spread_suggester
// per-channel sample ring with rank-count median and spread gate
// ----------------------------------------------------------------------------
// an evaluated beat passes meta, load and rank, n = filled samples
//   (n <= WINDOW); paced by the one-per-cycle sample memory reads and
//   the one-candidate-per-cycle rank pass
// input closed until idle: after meta below the sample threshold, after eval
//   or after emit (held by result stall); out-of-range beats are dropped
// reset: synchronous active low; clears fill/pointer valid bits, registers
//   return to min_samples 4 and spread_limit 60; sample memory is not cleared
module window_median_spread_suggester
  import wmss_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int WINDOW       = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input beat: [7:0] channel, [18:8] minute, [23:19] zero
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,
  // result beat: [7:0] suggest_channel, [18:8] suggest_minute, [23:19] zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int DEPTH = NUM_CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [MINS_W-1:0]   min_samples_r;
  logic [MINUTE_W-1:0] spread_limit_r;

  // sequencer
  state_t              state_r, state_nxt;
  logic [CHW-1:0]      ch_r;
  logic [MINUTE_W-1:0] minute_r;
  logic [CW-1:0]       n_r;
  logic [CW-1:0]       cnt_r;

  // sample memory, one ring of WINDOW entries per channel
  logic [MINUTE_W-1:0] smp_mem [DEPTH];
  logic [MINUTE_W-1:0] smp_q;
  logic [AW-1:0]       smp_raddr;
  logic [AW-1:0]       base;

  // pointer / fill memory with a valid bit per channel
  logic [IW+CW-1:0]    meta_mem [NUM_CHANNELS];
  logic [IW+CW-1:0]    meta_q;
  logic                meta_v_r;
  logic [NUM_CHANNELS-1:0] meta_vld_r;
  logic [IW-1:0]       wp;
  logic [CW-1:0]       fill;
  logic [IW-1:0]       wp_next;
  logic [CW-1:0]       fill_next;

  // working copy of the filled samples
  logic [MINUTE_W-1:0] buf_r [WINDOW];
  logic [MINUTE_W-1:0] lo_r, hi_r, mn_r, mx_r;
  logic [MINUTE_W-1:0] cand;
  logic [CW-1:0]       lt_cnt, le_cnt;
  logic [CW-1:0]       k1, k2;
  logic [MINUTE_W:0]   med_sum;
  logic [MINUTE_W-1:0] spread;

  // output register
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [DATA_W-1:0]   res_data_r;

  logic                in_acc;
  logic                ch_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign ch_ok      = (int'(in_tdata[CHANNEL_W-1:0]) < NUM_CHANNELS);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign base = AW'(ch_r) * AW'(WINDOW);

  // unwritten channel reads as pointer 0, fill 0
  assign wp   = meta_v_r ? meta_q[IW+CW-1:CW] : '0;
  assign fill = meta_v_r ? meta_q[CW-1:0]     : '0;
  assign wp_next   = (int'(wp) == WINDOW - 1) ? '0 : IW'(wp + 1'b1);
  assign fill_next = (int'(fill) == WINDOW) ? fill : CW'(fill + 1'b1);

  // sorted positions of the two middle values
  assign k1 = CW'((n_r - 1'b1) >> 1);
  assign k2 = CW'(n_r >> 1);

  // rank of the current candidate among the filled samples
  assign cand = buf_r[cnt_r[IW-1:0]];
  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (i < int'(n_r)) begin
        if (buf_r[i] < cand)  lt_cnt = CW'(lt_cnt + 1'b1);
        if (buf_r[i] <= cand) le_cnt = CW'(le_cnt + 1'b1);
      end
    end
  end

  assign med_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign spread  = mx_r - mn_r;

  always_comb begin
    smp_raddr = base + AW'(cnt_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && ch_ok) state_nxt = S_META;
      end
      S_META: begin
        if ({4'd0, fill_next} < {{(CW+4-MINS_W){1'b0}}, min_samples_r})
          state_nxt = S_IDLE;
        else
          state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (cnt_r == n_r) state_nxt = S_RANK;
      end
      S_RANK: begin
        if (cnt_r == CW'(n_r - 1'b1)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = (spread < spread_limit_r) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      min_samples_r  <= MIN_SAMPLES_RST;
      spread_limit_r <= SPREAD_LIMIT_RST;
      meta_vld_r     <= '0;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_SAMPLES:  min_samples_r  <= cfg_wdata[MINS_W-1:0];
          REG_SPREAD_LIMIT: spread_limit_r <= cfg_wdata[MINUTE_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_META) meta_vld_r[ch_r] <= 1'b1;
      if (state_r == S_EMIT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_META:  cnt_r <= '0;
        S_LOAD:  cnt_r <= (cnt_r == n_r) ? '0 : CW'(cnt_r + 1'b1);
        S_RANK:  cnt_r <= CW'(cnt_r + 1'b1);
        default: cnt_r <= '0;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r     <= in_tdata[CHW-1:0];
      minute_r <= in_tdata[CHANNEL_W +: MINUTE_W];
    end
    if (state_r == S_META) n_r <= fill_next;
    // read data lands in the cycle after its address
    if (state_r == S_LOAD && cnt_r != '0) buf_r[IW'(cnt_r - 1'b1)] <= smp_q;
    if (state_r == S_RANK) begin
      if (lt_cnt <= k1 && k1 < le_cnt) lo_r <= cand;
      if (lt_cnt <= k2 && k2 < le_cnt) hi_r <= cand;
      if (cnt_r == '0 || cand < mn_r) mn_r <= cand;
      if (cnt_r == '0 || cand > mx_r) mx_r <= cand;
    end
    if (state_r == S_EVAL) begin
      res_data_r <= {{(DATA_W-CHANNEL_W-MINUTE_W){1'b0}}, med_sum[MINUTE_W:1],
                     {(CHANNEL_W-CHW){1'b0}}, ch_r};
    end
    if (state_r == S_EMIT && (!out_valid_r || out_tready)) out_data_r <= res_data_r;
  end

  // sample memory: write in the meta cycle, read one entry a cycle in load
  always_ff @(posedge clk) begin
    if (state_r == S_META) smp_mem[base + AW'(wp)] <= minute_r;
    smp_q <= smp_mem[smp_raddr];
  end

  // pointer / fill memory
  always_ff @(posedge clk) begin
    if (state_r == S_META) meta_mem[ch_r] <= {wp_next, fill_next};
    if (in_acc) begin
      meta_q   <= meta_mem[in_tdata[CHW-1:0]];
      meta_v_r <= meta_vld_r[in_tdata[CHW-1:0]];
    end
  end

endmodule

// ----- design/wmss_checker.sv -----
// ----------------------------------------------------------------------------
// wmss_checker - port-level checks for the suggester
// watches the stream ports only
// ----------------------------------------------------------------------------
module wmss_checker
  import wmss_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [DATA_W-1:0] in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // padding above the minute stays zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DATA_W-1:CHANNEL_W+MINUTE_W] == '0)
    else $error("result padding not zero");

  // an in-range beat keeps the input closed while it is worked
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (int'(in_tdata[CHANNEL_W-1:0]) < NUM_CHANNELS)
    |=> !in_tready)
    else $error("input open during evaluation");

  // results only name valid channels
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[CHANNEL_W-1:0]) < NUM_CHANNELS)
    else $error("result for out-of-range channel");

  // no result straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind window_median_spread_suggester wmss_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_wmss_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .in_tdata(in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);
